@@ src/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring buffer deque package
// Field widths, action and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int ACT_W  = 2;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic load;
		logic exec;
	} rbd_cmd_t;

endpackage

@@ src/rbd_if.sv @@
// ----------------------------------------------------------------------------
// Ring buffer deque channels
// Valid/ready channels for actions, results and the capacity register.
// ----------------------------------------------------------------------------
interface rbd_in_if;
	import rbd_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [DATA_W-1:0] item_data;
	modport source (output valid, output action, output item_data, input ready);
	modport sink (input valid, input action, input item_data, output ready);
endinterface

interface rbd_out_if;
	import rbd_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [DATA_W-1:0] popped_data;
	logic [CNT_W-1:0]  occupancy;
	modport source (output valid, output status, output popped_data, output occupancy,
		input ready);
	modport sink (input valid, input status, input popped_data, input occupancy,
		output ready);
endinterface

interface rbd_cfg_if;
	import rbd_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] capacity;
	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

@@ src/rbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ring buffer deque controller
// Sequences one item: capture, execute against the buffer, hold the result.
// ----------------------------------------------------------------------------
module rbd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rbd_pkg::rbd_cmd_t cmd
);
	import rbd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);

endmodule

@@ src/rbd_datapath.sv @@
// ----------------------------------------------------------------------------
// Ring buffer deque datapath
// Slot memory, wrapping front/back indices, item count and result registers.
// ----------------------------------------------------------------------------
module rbd_datapath #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rbd_pkg::rbd_cmd_t             cmd,
	input  logic [rbd_pkg::ACT_W-1:0]     action,
	input  logic [rbd_pkg::DATA_W-1:0]    item_data,
	input  logic                          cfg_we,
	input  logic [rbd_pkg::CNT_W-1:0]     cfg_capacity,
	output logic [rbd_pkg::STAT_W-1:0]    status,
	output logic [rbd_pkg::DATA_W-1:0]    popped_data,
	output logic [rbd_pkg::CNT_W-1:0]     occupancy
);
	import rbd_pkg::*;

	localparam int IW      = $clog2(DEPTH);
	localparam int AW      = (IW > CNT_W) ? IW : CNT_W;
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam logic [CNT_W-1:0] CAP_MAX_C = CNT_W'(CAP_MAX);

	// Capacity is stored already clamped to the range one to the storage depth or 31, whichever is smaller.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] r;
		r = raw;
		if (raw == '0) begin
			r = CNT_W'(1);
		end else if (raw > CAP_MAX_C) begin
			r = CAP_MAX_C;
		end
		return r;
	endfunction

	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
		input logic [AW-1:0] c);
		logic [AW-1:0] n;
		n = AW'(i) + AW'(1);
		return (n >= c) ? '0 : IW'(n);
	endfunction

	function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
		input logic [AW-1:0] c);
		logic [AW-1:0] p;
		p = c - AW'(1);
		return (i == '0) ? IW'(p) : (i - IW'(1));
	endfunction

	logic [CNT_W-1:0]         cap_q;
	logic [IW-1:0]            front_q;
	logic [IW-1:0]            back_q;
	logic [CNT_W-1:0]         count_q;
	logic [ACT_W-1:0]         action_q;
	logic [PAYLOAD_WIDTH-1:0] data_q;
	logic [STAT_W-1:0]        status_q;
	logic                     pop_ok_q;
	logic [PAYLOAD_WIDTH-1:0] rd_q;
	logic [PAYLOAD_WIDTH-1:0] mem [DEPTH];

	logic [AW-1:0]     cap_a;
	logic              full;
	logic              empty;
	logic [IW-1:0]     front_next;
	logic [IW-1:0]     front_prev;
	logic [IW-1:0]     back_next;
	logic [IW-1:0]     back_prev;
	logic              we;
	logic              re;
	logic [IW-1:0]     waddr;
	logic [IW-1:0]     raddr;
	logic [IW-1:0]     front_d;
	logic [IW-1:0]     back_d;
	logic [CNT_W-1:0]  count_d;
	logic [STAT_W-1:0] status_d;

	assign cap_a      = AW'(cap_q);
	assign full       = (count_q >= cap_q);
	assign empty      = (count_q == '0);
	assign front_next = idx_next(front_q, cap_a);
	assign front_prev = idx_prev(front_q, cap_a);
	assign back_next  = idx_next(back_q, cap_a);
	assign back_prev  = idx_prev(back_q, cap_a);

	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		waddr    = back_q;
		raddr    = front_q;
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		status_d = ST_OK;
		case (action_q)
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we      = 1'b1;
					waddr   = front_prev;
					front_d = front_prev;
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we      = 1'b1;
					waddr   = back_q;
					back_d  = back_next;
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = front_q;
					front_d = front_next;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = back_prev;
					back_d  = back_prev;
					count_d = count_q - CNT_W'(1);
				end
			end
		endcase
	end

	// A capacity write empties the queue; slot contents stay as they are.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= eff_cap(CAP_RESET);
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= eff_cap(cfg_capacity);
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			data_q   <= PAYLOAD_WIDTH'(item_data);
		end
		if (cmd.exec) begin
			status_q <= status_d;
			pop_ok_q <= re;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			mem[waddr] <= data_q;
		end
		if (cmd.exec && re) begin
			rd_q <= mem[raddr];
		end
	end

	assign status      = status_q;
	assign popped_data = pop_ok_q ? DATA_W'(rd_q) : '0;
	assign occupancy   = count_q;

endmodule

@@ src/ring_buffer_deque_top.sv @@
// ----------------------------------------------------------------------------
// Ring buffer deque top level
// Double-ended queue in a circular slot memory with a programmable capacity.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is captured, then executed in the execute state,
// and its result is held in the response state until the output takes it.
// Item flow: a new item is accepted only after the previous result is taken; the
// slot memory is read or written in the execute state, then held for output.
// Reset: asynchronous, active low; the queue is empty and capacity is 16
// (clamped to DEPTH). Slot contents are not cleared.
module ring_buffer_deque_top #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input logic      clk,
	input logic      arst_n,
	rbd_in_if.sink   in_ch,
	rbd_out_if.source out_ch,
	rbd_cfg_if.sink  cfg_ch
);
	import rbd_pkg::*;

	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

	rbd_cmd_t cmd;

	assign cfg_ch.ready = 1'b1;

	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	rbd_datapath #(
		.DEPTH         (DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (in_ch.action),
		.item_data    (in_ch.item_data),
		.cfg_we       (cfg_ch.valid && cfg_ch.ready),
		.cfg_capacity (cfg_ch.capacity),
		.status       (out_ch.status),
		.popped_data  (out_ch.popped_data),
		.occupancy    (out_ch.occupancy)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input accepted while a result is pending");

	a_exec_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> cmd.exec)
		else $error("accepted item was not executed in the next cycle");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.occupancy <= CNT_W'(CAP_MAX)))
		else $error("occupancy exceeds the storage limit");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.popped_data == '0))
		else $error("refused action returned nonzero data");

endmodule

@@ dv/ring_buffer_deque_top_tb.sv @@
// ----------------------------------------------------------------------------
// Ring buffer deque testbench
// Sends push and pop actions at both ends of the deque, over a range of
// capacity settings, with random gaps and output stalls. Every result is
// checked field by field against a behavioral copy of the deque.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top_tb;
	import rbd_pkg::*;

	localparam int DEPTH         = 16;
	localparam int IDX_W         = $clog2(DEPTH);
	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 12;
	localparam int PHASE_ITEMS   = 65;
	localparam int NUM_PHASES    = 10;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [DATA_W-1:0] item_data;
	} deque_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] popped_data;
		logic [CNT_W-1:0]  occupancy;
	} deque_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	rbd_in_if  in_ch();
	rbd_out_if out_ch();
	rbd_cfg_if cfg_ch();

	ring_buffer_deque_top #(
		.DEPTH(DEPTH),
		.PAYLOAD_WIDTH(DATA_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Behavioral copy of the deque.
	logic [DATA_W-1:0] slot_mirror [DEPTH];
	logic [IDX_W-1:0]  front_pos;
	logic [IDX_W-1:0]  back_pos;
	logic [CNT_W-1:0]  fill_level;
	logic [CNT_W-1:0]  cap_setting;

	deque_req_t   actions_to_send [$];
	deque_reply_t replies_due [$];
	int unsigned  items_unaccepted;

	int unsigned errors;
	int unsigned results_seen;
	int unsigned refused_pushes;
	int unsigned refused_pops;
	int unsigned cap_writes;
	int unsigned idle_left;
	int unsigned stall_left;
	logic        gaps_on;
	logic        stalls_on;

	function automatic int unsigned usable_slots();
		if (cap_setting == '0)
			return 1;
		if (cap_setting > DEPTH)
			return DEPTH;
		return 32'(cap_setting);
	endfunction

	function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i);
		int unsigned n;
		n = i + 1;
		return (n >= usable_slots()) ? '0 : IDX_W'(n);
	endfunction

	function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i);
		int unsigned c;
		c = usable_slots();
		if (i == '0 || i > c)
			return IDX_W'(c - 1);
		return i - 1'b1;
	endfunction

	function automatic void predict_reply(deque_req_t req);
		deque_reply_t r;
		logic         full;
		logic         empty;
		full  = fill_level >= usable_slots();
		empty = fill_level == '0;
		r.status      = ST_OK;
		r.popped_data = '0;
		case (req.action)
			ACT_PUSH_FRONT: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					front_pos = step_down(front_pos);
					slot_mirror[front_pos] = req.item_data;
					fill_level++;
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					slot_mirror[back_pos] = req.item_data;
					back_pos = step_up(back_pos);
					fill_level++;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_data = slot_mirror[front_pos];
					front_pos = step_up(front_pos);
					fill_level--;
				end
			end
			default: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					back_pos = step_down(back_pos);
					r.popped_data = slot_mirror[back_pos];
					fill_level--;
				end
			end
		endcase
		if (r.status == ST_FULL)
			refused_pushes++;
		if (r.status == ST_EMPTY)
			refused_pops++;
		r.occupancy = fill_level;
		replies_due.push_back(r);
	endfunction

	function automatic void report_error(string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic void queue_action(logic [ACT_W-1:0] act, logic [DATA_W-1:0] data);
		deque_req_t req;
		req.action    = act;
		req.item_data = data;
		actions_to_send.push_back(req);
		items_unaccepted++;
	endfunction

	// Runs of push-heavy or pop-heavy traffic so that the deque fills to its
	// capacity and drains to empty many times; some runs are evenly mixed.
	function automatic void queue_random_actions(int unsigned count);
		int unsigned left;
		int unsigned run_len;
		int unsigned push_pct;
		logic        at_front;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(1, 24);
			case ($urandom_range(0, 3))
				0: push_pct = 85;
				1: push_pct = 15;
				2: push_pct = 50;
				default: push_pct = 70;
			endcase
			while (run_len > 0 && left > 0) begin
				at_front = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < push_pct)
					queue_action(at_front ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_data());
				else
					queue_action(at_front ? ACT_POP_FRONT : ACT_POP_BACK, pick_data());
				run_len--;
				left--;
			end
		end
	endfunction

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.capacity <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		// A capacity write empties the deque but keeps the slot contents.
		cap_setting = value;
		front_pos   = '0;
		back_pos    = '0;
		fill_level  = '0;
		cap_writes++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (items_unaccepted != 0 || replies_due.size() != 0);
	endtask

	// Driver: presents one item at a time from the pending queue.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			idle_left = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				predict_reply('{action: in_ch.action, item_data: in_ch.item_data});
				items_unaccepted--;
				idle_left = gaps_on ? pick_gap() : 0;
			end
			if (idle_left == 0 && actions_to_send.size() != 0) begin
				deque_req_t req;
				req = actions_to_send.pop_front();
				in_ch.valid     <= 1'b1;
				in_ch.action    <= req.action;
				in_ch.item_data <= req.item_data;
			end else begin
				in_ch.valid <= 1'b0;
				if (idle_left > 0)
					idle_left--;
			end
		end
	end

	// Monitor: checks each accepted result and stalls the output at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					report_error($sformatf("result %0d arrived with none expected", results_seen));
				end else begin
					deque_reply_t want;
					want = replies_due.pop_front();
					if (out_ch.status !== want.status)
						report_error($sformatf("result %0d status: expected %0d, got %0d",
							results_seen, want.status, out_ch.status));
					if (out_ch.popped_data !== want.popped_data)
						report_error($sformatf("result %0d popped_data: expected 0x%08h, got 0x%08h",
							results_seen, want.popped_data, out_ch.popped_data));
					if (out_ch.occupancy !== want.occupancy)
						report_error($sformatf("result %0d occupancy: expected %0d, got %0d",
							results_seen, want.occupancy, out_ch.occupancy));
				end
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (stalls_on && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("ring_buffer_deque_top test failed");
		$finish;
	end

	initial begin : stimulus
		logic [CNT_W-1:0] cap_plan [NUM_PHASES];
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.action    = ACT_PUSH_FRONT;
		in_ch.item_data = '0;
		out_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.capacity = CAP_RESET;
		gaps_on         = 1'b0;
		stalls_on       = 1'b0;
		errors          = 0;
		results_seen    = 0;
		refused_pushes  = 0;
		refused_pops    = 0;
		cap_writes      = 0;
		items_unaccepted = 0;
		cap_setting     = CAP_RESET;
		front_pos       = '0;
		back_pos        = '0;
		fill_level      = '0;
		foreach (slot_mirror[i])
			slot_mirror[i] = '0;
		cap_plan = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd3, 5'd17, 5'd15, 5'd0, 5'd0};
		cap_plan[8] = CNT_W'($urandom_range(0, 31));
		cap_plan[9] = CNT_W'($urandom_range(0, 31));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset capacity: pops on an empty deque, both ends, data extremes.
		queue_action(ACT_POP_FRONT, '1);
		queue_action(ACT_POP_BACK, '0);
		queue_action(ACT_PUSH_FRONT, '0);
		queue_action(ACT_PUSH_BACK, '1);
		queue_action(ACT_PUSH_FRONT, 32'hA5A5_5A5A);
		queue_action(ACT_POP_BACK, '0);
		queue_action(ACT_POP_FRONT, '0);
		queue_action(ACT_POP_FRONT, '0);
		queue_action(ACT_POP_BACK, '0);
		wait_drained();

		// A capacity of zero behaves as one slot, so the second push is refused.
		write_capacity(5'd0);
		queue_action(ACT_PUSH_BACK, 32'h1234_5678);
		queue_action(ACT_PUSH_FRONT, 32'h8765_4321);
		queue_action(ACT_POP_BACK, '0);
		queue_action(ACT_PUSH_FRONT, 32'hFFFF_0000);
		queue_action(ACT_POP_FRONT, '0);
		queue_action(ACT_PUSH_BACK, 32'h0000_FFFF);
		wait_drained();

		// A capacity above the depth is clamped; the write drops the stored item.
		// Front pushes then wrap below slot zero and are popped from the back.
		write_capacity(5'd31);
		queue_action(ACT_POP_BACK, '0);
		queue_action(ACT_POP_FRONT, '0);
		queue_action(ACT_PUSH_FRONT, 32'h0000_0001);
		queue_action(ACT_PUSH_FRONT, 32'h8000_0002);
		queue_action(ACT_POP_BACK, '0);
		queue_action(ACT_POP_BACK, '0);
		wait_drained();

		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(cap_plan[p]);
			// Some phases run with no gaps or no stalls at all.
			gaps_on   = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			queue_random_actions(PHASE_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			report_error($sformatf("%0d results never arrived", replies_due.size()));

		$display("Checked %0d results across %0d capacity writes, including zero and values",
			results_seen, cap_writes);
		$display("above the depth; %0d pushes refused on full, %0d pops refused on empty.",
			refused_pushes, refused_pops);
		if (errors > REPORT_LIMIT)
			$display("%0d further errors not shown", errors - REPORT_LIMIT);
		if (errors == 0) begin
			$display("ring_buffer_deque_top test passed");
		end else begin
			$display("ring_buffer_deque_top test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/rbd_pkg.sv
src/rbd_if.sv
src/rbd_ctrl.sv
src/rbd_datapath.sv
src/ring_buffer_deque_top.sv
dv/ring_buffer_deque_top_tb.sv
